>>> sv/lapse_timer_three_mode_unit_defines.svh
// Assertion macros for the lapse timer block.
`ifndef LAPSE_TIMER_THREE_MODE_UNIT_DEFINES_SVH
`define LAPSE_TIMER_THREE_MODE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define LT3M_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lapse timer check failed");
// Next-cycle implication, disabled during reset
`define LT3M_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lapse timer check failed");
`else
`define LT3M_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define LT3M_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> sv/lt3m_pkg.sv
package lt3m_pkg;

    // Fixed-point format of the measure
    localparam int FRACTION_BITS = 16;
    localparam int MEAS_W        = 49;
    localparam int TIME_W        = 32;

    // Divider dividend: time magnitude scaled by the fraction
    localparam int DIVIDEND_W = TIME_W + FRACTION_BITS;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

    // Working width before saturation
    localparam int WIDE_W = (TIME_W + 2 + FRACTION_BITS > MEAS_W + 1) ?
                            (TIME_W + 2 + FRACTION_BITS) : (MEAS_W + 1);

    localparam logic signed [WIDE_W-1:0] SAT_HI =
        {{(WIDE_W-MEAS_W+1){1'b0}}, {(MEAS_W-1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] SAT_LO =
        {{(WIDE_W-MEAS_W+1){1'b1}}, {(MEAS_W-1){1'b0}}};

    // Read modes
    localparam logic [1:0] MODE_OFFSET = 2'd0;
    localparam logic [1:0] MODE_RATIO  = 2'd1;
    localparam logic [1:0] MODE_WHOLE  = 2'd2;

    // Request kinds
    localparam logic OP_ARM  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Register indexes
    localparam logic CFG_MODE   = 1'b0;
    localparam logic CFG_PERIOD = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIVIDE,
        ST_FIX,
        ST_OUTPUT
    } lt3m_state_t;

    // Clamp a wide signed value into the measure range
    function automatic logic [MEAS_W-1:0] sat_meas(logic signed [WIDE_W-1:0] v);
        logic [MEAS_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[MEAS_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[MEAS_W-1:0];
        end else begin
            r = v[MEAS_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> sv/lt3m_div.sv
module lt3m_div import lt3m_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [TIME_W-1:0]     divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [TIME_W-1:0]     remainder
);

    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic                  done_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [TIME_W-1:0]     rem_reg;
    logic [TIME_W-1:0]     den_reg;
    logic [TIME_W:0]       partial;
    logic                  fits;

    // One restoring step: shift in the next dividend bit and try the subtract
    assign partial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits    = (partial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= DIV_CNT_W'(DIVIDEND_W);
            end else if (cnt_reg != '0) begin
                cnt_reg  <= cnt_reg - 1'b1;
                done_reg <= (cnt_reg == DIV_CNT_W'(1));
            end
        end
    end

    // Hold the operands and advance one quotient bit a cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (cnt_reg != '0) begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? TIME_W'(partial - {1'b0, den_reg}) : partial[TIME_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> sv/lapse_timer_three_mode_unit.sv
// Lapse timer with offset, ratio and whole-period read modes.
// Requests arrive on the s_ channel: s_tuser is the kind (0 arm, 1 read),
// s_tdata carries now, start_time and use_now. Every request gives exactly
// one result on the m_ channel: m_tdata holds the signed Q32.16 measure,
// m_tuser flags a read of a timer that was never armed.
// The user writes mode and period through the cfg_ port only while the block is
// idle; the block does not enforce it, and cfg_ready is always high.
// Arm, unarmed read, offset read and the unused mode pass from acceptance
// through ST_EVAL and ST_OUTPUT to m_tvalid. Ratio and whole-period reads run a
// bit-serial restoring divider, one quotient bit a cycle over 48 bits,
// in ST_DIVIDE before ST_FIX. s_tready is high only while the sequencer is idle,
// so a new request is taken only once the last result is in the output register.
// The result sits in an output register; a stalled receiver holds it and
// the next request is taken, but its result waits until that one is taken.
// Reset (aresetn low, synchronous) clears the timer to unarmed, reference 0,
// mode offset and period 1, and drops any pending result.
`include "lapse_timer_three_mode_unit_defines.svh"

module lapse_timer_three_mode_unit import lt3m_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    // Configuration writes
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_index,
    input  logic [31:0]   cfg_data,
    // Requests
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [71:0]   s_tdata,   // now[31:0], start_time[63:32], use_now[64], zero
    input  logic          s_tuser,   // operation
    // Results
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [55:0]   m_tdata,   // measure[48:0], zero
    output logic          m_tuser    // not_armed
);

    lt3m_state_t           state_reg, state_next;
    logic [1:0]            mode_reg;
    logic [TIME_W-1:0]     period_reg;
    logic [TIME_W-1:0]     ref_reg, ref_next;
    logic                  armed_reg, armed_next;

    logic                  op_reg, use_now_reg, neg_reg, neg_next;
    logic [TIME_W-1:0]     now_reg, start_reg;
    logic [MEAS_W-1:0]     res_meas_reg, res_meas_next;
    logic                  res_nota_reg, res_nota_next;

    logic                  m_valid_reg;
    logic [MEAS_W-1:0]     m_meas_reg;
    logic                  m_nota_reg;

    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [TIME_W-1:0]     div_divisor;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_quo;
    logic [TIME_W-1:0]     div_rem;

    logic signed [TIME_W+1:0] x_off;
    logic signed [TIME_W:0]   d_diff;
    logic [TIME_W-1:0]        d_mag;
    logic [DIVIDEND_W:0]      q_adj;
    logic signed [WIDE_W-1:0] x_wide, q_wide, q_scaled;
    logic                     s_accept, out_free;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_OFFSET;
            period_reg <= TIME_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MODE:   mode_reg   <= cfg_data[1:0];
                CFG_PERIOD: period_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Datapath terms used by the sequencer
    assign d_diff = $signed({1'b0, now_reg}) - $signed({1'b0, ref_reg});
    assign d_mag  = d_diff[TIME_W] ? TIME_W'(-d_diff) : d_diff[TIME_W-1:0];
    assign x_off  = $signed({2'b00, now_reg}) - $signed({2'b00, ref_reg})
                    - $signed({2'b00, period_reg});
    assign x_wide = WIDE_W'(x_off) <<< FRACTION_BITS;

    assign div_divisor  = (period_reg == '0) ? TIME_W'(1) : period_reg;
    assign div_dividend = (mode_reg == MODE_RATIO) ?
                          ({d_mag, {FRACTION_BITS{1'b0}}}) : DIVIDEND_W'(d_mag);

    // Floor correction of the magnitude quotient for a negative lapse
    assign q_adj    = {1'b0, div_quo} + (DIVIDEND_W+1)'(div_rem != '0);
    assign q_wide   = neg_reg ? -$signed(WIDE_W'(q_adj)) : $signed(WIDE_W'(div_quo));
    assign q_scaled = q_wide <<< FRACTION_BITS;

    lt3m_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Sequencer state and timer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ref_reg   <= '0;
            armed_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ref_reg   <= ref_next;
            armed_reg <= armed_next;
        end
    end

    // Capture the request and the working result
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg      <= s_tuser;
            now_reg     <= s_tdata[31:0];
            start_reg   <= s_tdata[63:32];
            use_now_reg <= s_tdata[64];
        end
        neg_reg      <= neg_next;
        res_meas_reg <= res_meas_next;
        res_nota_reg <= res_nota_next;
    end

    // Next state, timer update and result
    always_comb begin
        state_next    = state_reg;
        ref_next      = ref_reg;
        armed_next    = armed_reg;
        neg_next      = neg_reg;
        res_meas_next = res_meas_reg;
        res_nota_next = res_nota_reg;
        div_start     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                res_meas_next = '0;
                res_nota_next = 1'b0;
                state_next    = ST_OUTPUT;
                if (op_reg == OP_ARM) begin
                    ref_next   = use_now_reg ? now_reg : start_reg;
                    armed_next = 1'b1;
                end else if (!armed_reg) begin
                    res_nota_next = 1'b1;
                end else begin
                    case (mode_reg)
                        MODE_OFFSET: begin
                            res_meas_next = sat_meas(x_wide);
                            if (!x_off[TIME_W+1]) begin
                                ref_next = now_reg;
                            end
                        end
                        MODE_RATIO, MODE_WHOLE: begin
                            neg_next   = d_diff[TIME_W];
                            div_start  = 1'b1;
                            state_next = ST_DIVIDE;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX: begin
                state_next = ST_OUTPUT;
                if (mode_reg == MODE_RATIO) begin
                    res_meas_next = sat_meas(q_wide);
                    if (!neg_reg) begin
                        ref_next = now_reg;
                    end
                end else begin
                    res_meas_next = sat_meas(q_scaled);
                    // Advancing by whole periods leaves the remainder behind
                    if (!neg_reg && div_quo != '0) begin
                        ref_next = now_reg - div_rem;
                    end
                end
            end
            ST_OUTPUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: load when free, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUTPUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUTPUT && out_free) begin
            m_meas_reg <= res_meas_reg;
            m_nota_reg <= res_nota_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(56-MEAS_W){1'b0}}, m_meas_reg};
    assign m_tuser  = m_nota_reg;

    // Checks
    `LT3M_ASSERT_NOW(a_nota_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata == '0)
    `LT3M_ASSERT_NOW(a_div_in_state, aclk, aresetn, div_done, state_reg == ST_DIVIDE)
    `LT3M_ASSERT_NEXT(a_busy_after_take, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `LT3M_ASSERT_NEXT(a_armed_stays, aclk, aresetn, armed_reg, armed_reg)

endmodule
